// ===== design/pdt_pkg.sv =====
// Shared types and codes for the piece descriptor table.
`default_nettype none
package pdt_pkg;

  // Width of document positions, offsets and lengths.
  localparam int POS_BITS = 24;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Status codes of a result beat.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOP   = 2'd1;
  localparam logic [1:0] ST_TABLE = 2'd2;
  localparam logic [1:0] ST_SPACE = 2'd3;

  // One piece descriptor.
  typedef struct packed {
    logic                from_add;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] length;
  } ent_t;

endpackage
`default_nettype wire

// ===== design/piece_descriptor_table_core.sv =====
// Piece descriptor table: ordered descriptor memory with an edit sequencer.
`default_nettype none
// The descriptors live in a single-port-pair memory (one write, one registered read per
// cycle), and one small sequencer does every edit. A restart and an insert at the end of
// the document or into an empty table finish in the decode state, and a query then reads
// its descriptor. Other inserts and removes walk the descriptors to find the position or
// the end of the range, move descriptors when the table is opened or closed, and write
// the new or trimmed descriptors. Walked and moved descriptors are read through the
// registered port before use. in_stall is high while an item is in work; a new item is
// taken while the previous result still waits on the output register.
module piece_descriptor_table_core
  import pdt_pkg::*;
#(
  parameter int MAX_PIECES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [POS_BITS-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_op,
  input  wire logic [POS_BITS-1:0] in_position,
  input  wire logic [POS_BITS-1:0] in_count,
  input  wire logic [5:0]          in_entry_index,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic                     out_piece_valid,
  output logic                     out_piece_from_add,
  output logic [POS_BITS-1:0]      out_piece_start,
  output logic [POS_BITS-1:0]      out_piece_length,
  output logic [POS_BITS-1:0]      out_doc_length,
  output logic [6:0]               out_piece_total
);

  localparam int AW = $clog2(MAX_PIECES);
  localparam int CW = $clog2(MAX_PIECES + 1);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PIECES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_LRD    = 4'd2;
  localparam logic [3:0] S_LCHK   = 4'd3;
  localparam logic [3:0] S_FND    = 4'd4;
  localparam logic [3:0] S_CPRD   = 4'd5;
  localparam logic [3:0] S_CPWR   = 4'd6;
  localparam logic [3:0] S_WR     = 4'd7;
  localparam logic [3:0] S_RMRD   = 4'd8;
  localparam logic [3:0] S_RMCHK  = 4'd9;
  localparam logic [3:0] S_QRY    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;
  localparam logic [3:0] S_RMSTOP = 4'd12;

  // Descriptor memory.
  ent_t desc_mem [MAX_PIECES];
  ent_t mem_rdata_r;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  ent_t mem_wdata;

  logic [3:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt, cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic [5:0] ei_r, ei_nxt;
  logic [CW-1:0] idx_r, idx_nxt, j_r, j_nxt, keep_r, keep_nxt;
  logic [POS_BITS-1:0] base_r, base_nxt, off_r, off_nxt;
  ent_t e_r, e_nxt, tail_r, tail_nxt;
  logic [1:0] wstep_r, wstep_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic res_valid_r, res_valid_nxt, res_src_r, res_src_nxt;
  logic [POS_BITS-1:0] res_st_r, res_st_nxt, res_ln_r, res_ln_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [POS_BITS-1:0] add_r, add_nxt, total_r, total_nxt, orig_r;
  logic [CW-1:0] cp_i_r, cp_i_nxt, cp_stop_r, cp_stop_nxt, cp_dist_r, cp_dist_nxt;
  logic cp_up_r, cp_up_nxt;
  logic [3:0] cp_ret_r, cp_ret_nxt;
  logic out_valid_r;
  logic [1:0] out_status_r;
  logic out_pv_r, out_src_r;
  logic [POS_BITS-1:0] out_st_r, out_ln_r, out_doc_r;
  logic [CW-1:0] out_cnt_r;

  // Helper values used by the sequencer.
  logic [POS_BITS:0] sum_add, sum_total, loc_end, span;
  logic [CW+5:0] ei_x, cnt_x;
  logic [CW:0] need_tot;
  logic [CW-1:0] need, lo, cp_dst, delta, tail_at;
  logic [CW+6:0] total_x;
  ent_t new_ent;
  logic out_load;

  assign sum_add   = {1'b0, add_r} + {1'b0, cnt_r};
  assign sum_total = {1'b0, total_r} + {1'b0, cnt_r};
  assign loc_end   = {1'b0, base_r} + {1'b0, mem_rdata_r.length};
  assign span      = {1'b0, off_r} + {1'b0, rem_r};
  assign ei_x      = {{CW{1'b0}}, ei_r};
  assign cnt_x     = {6'b0, count_r};
  assign need      = (off_r == '0) ? ONE_C : TWO_C;
  assign need_tot  = {1'b0, count_r} + {1'b0, need};
  assign lo        = (off_r == '0) ? idx_r : idx_r + ONE_C;
  assign cp_dst    = cp_up_r ? cp_i_r + cp_dist_r : cp_i_r - cp_dist_r;
  assign delta     = j_r - keep_r;
  assign tail_at   = (op_r == OP_INSERT) ? idx_r + TWO_C : idx_r + ONE_C;
  assign new_ent   = '{from_add: 1'b1, start: add_r, length: cnt_r};
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Sequencer.
  always_comb begin
    state_nxt = state_r; op_nxt = op_r; pos_nxt = pos_r; cnt_nxt = cnt_r;
    rem_nxt = rem_r; ei_nxt = ei_r; idx_nxt = idx_r; j_nxt = j_r; keep_nxt = keep_r;
    base_nxt = base_r; off_nxt = off_r; e_nxt = e_r; tail_nxt = tail_r;
    wstep_nxt = wstep_r; res_status_nxt = res_status_r; res_valid_nxt = res_valid_r;
    res_src_nxt = res_src_r; res_st_nxt = res_st_r; res_ln_nxt = res_ln_r;
    count_nxt = count_r; add_nxt = add_r; total_nxt = total_r;
    cp_i_nxt = cp_i_r; cp_stop_nxt = cp_stop_r; cp_dist_nxt = cp_dist_r;
    cp_up_nxt = cp_up_r; cp_ret_nxt = cp_ret_r;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = new_ent; mem_raddr = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op; pos_nxt = in_position; cnt_nxt = in_count;
          ei_nxt = in_entry_index;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_status_nxt = ST_DONE; res_valid_nxt = 1'b0; res_src_nxt = 1'b0;
        res_st_nxt = '0; res_ln_nxt = '0;
        idx_nxt = '0; base_nxt = '0; wstep_nxt = '0;
        state_nxt = S_DONE;
        unique case (op_r)
          OP_INSERT: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_NOP;
            end else if (sum_add[POS_BITS] || sum_total[POS_BITS]) begin
              res_status_nxt = ST_SPACE;
            end else if (count_r == '0 || pos_r >= total_r) begin
              if (count_r >= MAX_C) begin
                res_status_nxt = ST_TABLE;
              end else begin
                mem_we = 1'b1; mem_waddr = count_r[AW-1:0]; mem_wdata = new_ent;
                count_nxt = count_r + ONE_C;
                add_nxt = sum_add[POS_BITS-1:0];
                total_nxt = sum_total[POS_BITS-1:0];
              end
            end else begin
              state_nxt = S_LRD;
            end
          end
          OP_REMOVE: begin
            if (cnt_r == '0 || pos_r >= total_r) begin
              res_status_nxt = ST_NOP;
            end else begin
              rem_nxt = (cnt_r > total_r - pos_r) ? total_r - pos_r : cnt_r;
              state_nxt = S_LRD;
            end
          end
          OP_QUERY: begin
            if (ei_x < cnt_x) begin
              mem_raddr = ei_x[AW-1:0];
              state_nxt = S_QRY;
            end else begin
              res_status_nxt = ST_NOP;
            end
          end
          default: begin
            add_nxt = '0;
            total_nxt = orig_r;
            count_nxt = (orig_r != '0) ? ONE_C : '0;
            mem_we = (orig_r != '0); mem_waddr = '0;
            mem_wdata = '{from_add: 1'b0, start: '0, length: orig_r};
          end
        endcase
      end
      S_LRD: begin
        mem_raddr = idx_r[AW-1:0];
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        // The piece holding the position ends past it.
        if ({1'b0, pos_r} < loc_end) begin
          off_nxt = pos_r - base_r;
          e_nxt = mem_rdata_r;
          state_nxt = S_FND;
        end else begin
          base_nxt = loc_end[POS_BITS-1:0];
          idx_nxt = idx_r + ONE_C;
          state_nxt = S_LRD;
        end
      end
      S_FND: begin
        wstep_nxt = '0;
        if (op_r == OP_INSERT) begin
          tail_nxt = '{from_add: e_r.from_add, start: e_r.start + off_r,
                       length: e_r.length - off_r};
          if (need_tot > {1'b0, MAX_C}) begin
            res_status_nxt = ST_TABLE; state_nxt = S_DONE;
          end else if (count_r > lo) begin
            cp_up_nxt = 1'b1; cp_i_nxt = count_r - ONE_C; cp_stop_nxt = lo;
            cp_dist_nxt = need; cp_ret_nxt = S_WR; state_nxt = S_CPRD;
          end else begin
            state_nxt = S_WR;
          end
        end else if (span < {1'b0, e_r.length} && off_r != '0) begin
          // Range sits inside one piece: split it in two.
          tail_nxt = '{from_add: e_r.from_add, start: e_r.start + span[POS_BITS-1:0],
                       length: e_r.length - span[POS_BITS-1:0]};
          if (count_r >= MAX_C) begin
            res_status_nxt = ST_TABLE; state_nxt = S_DONE;
          end else if (count_r > idx_r + ONE_C) begin
            cp_up_nxt = 1'b1; cp_i_nxt = count_r - ONE_C; cp_stop_nxt = idx_r + ONE_C;
            cp_dist_nxt = ONE_C; cp_ret_nxt = S_WR; state_nxt = S_CPRD;
          end else begin
            state_nxt = S_WR;
          end
        end else if (span < {1'b0, e_r.length}) begin
          // Range is the head of one piece: trim its front.
          mem_we = 1'b1; mem_waddr = idx_r[AW-1:0];
          mem_wdata = '{from_add: e_r.from_add, start: e_r.start + rem_r,
                        length: e_r.length - rem_r};
          total_nxt = total_r - rem_r;
          state_nxt = S_DONE;
        end else begin
          // Range reaches the end of this piece: trim or drop it, then walk on.
          if (off_r != '0) begin
            mem_we = 1'b1; mem_waddr = idx_r[AW-1:0];
            mem_wdata = '{from_add: e_r.from_add, start: e_r.start, length: off_r};
            keep_nxt = idx_r + ONE_C;
          end else begin
            keep_nxt = idx_r;
          end
          rem_nxt = rem_r + off_r - e_r.length;
          total_nxt = total_r - rem_r;
          j_nxt = idx_r + ONE_C;
          state_nxt = S_RMRD;
        end
      end
      S_RMRD: begin
        mem_raddr = j_r[AW-1:0];
        state_nxt = (rem_r == '0 || j_r == count_r) ? S_RMSTOP : S_RMCHK;
      end
      S_RMCHK: begin
        if (rem_r >= mem_rdata_r.length) begin
          rem_nxt = rem_r - mem_rdata_r.length;
          j_nxt = j_r + ONE_C;
          state_nxt = S_RMRD;
        end else begin
          mem_we = 1'b1; mem_waddr = j_r[AW-1:0];
          mem_wdata = '{from_add: mem_rdata_r.from_add,
                        start: mem_rdata_r.start + rem_r,
                        length: mem_rdata_r.length - rem_r};
          rem_nxt = '0;
          state_nxt = S_RMSTOP;
        end
      end
      S_RMSTOP: begin
        // Close the gap left by the dropped pieces.
        count_nxt = count_r - delta;
        state_nxt = S_DONE;
        if (delta != '0 && j_r < count_r) begin
          cp_up_nxt = 1'b0; cp_i_nxt = j_r; cp_stop_nxt = count_r - ONE_C;
          cp_dist_nxt = delta; cp_ret_nxt = S_DONE; state_nxt = S_CPRD;
        end
      end
      S_CPRD: begin
        mem_raddr = cp_i_r[AW-1:0];
        state_nxt = S_CPWR;
      end
      S_CPWR: begin
        mem_we = 1'b1; mem_waddr = cp_dst[AW-1:0]; mem_wdata = mem_rdata_r;
        if (cp_i_r == cp_stop_r) begin
          state_nxt = cp_ret_r;
        end else begin
          cp_i_nxt = cp_up_r ? cp_i_r - ONE_C : cp_i_r + ONE_C;
          state_nxt = S_CPRD;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        wstep_nxt = wstep_r + 2'd1;
        if (op_r == OP_INSERT && off_r == '0) begin
          mem_waddr = idx_r[AW-1:0]; mem_wdata = new_ent;
        end else if (wstep_r == 2'd0) begin
          mem_waddr = idx_r[AW-1:0];
          mem_wdata = '{from_add: e_r.from_add, start: e_r.start, length: off_r};
        end else if (op_r == OP_INSERT && wstep_r == 2'd1) begin
          mem_waddr = lo[AW-1:0]; mem_wdata = new_ent;
        end else begin
          mem_waddr = tail_at[AW-1:0];
          mem_wdata = tail_r;
        end
        if (op_r == OP_INSERT && (off_r == '0 || wstep_r == 2'd2)) begin
          count_nxt = need_tot[CW-1:0];
          add_nxt = sum_add[POS_BITS-1:0];
          total_nxt = sum_total[POS_BITS-1:0];
          state_nxt = S_DONE;
        end else if (op_r != OP_INSERT && wstep_r == 2'd1) begin
          count_nxt = count_r + ONE_C;
          total_nxt = total_r - rem_r;
          state_nxt = S_DONE;
        end
      end
      S_QRY: begin
        res_valid_nxt = 1'b1;
        res_src_nxt = mem_rdata_r.from_add;
        res_st_nxt = mem_rdata_r.start;
        res_ln_nxt = mem_rdata_r.length;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Descriptor memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) desc_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= desc_mem[mem_raddr];
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      add_r <= '0;
      total_r <= '0;
      orig_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      add_r <= add_nxt;
      total_r <= total_nxt;
      if (cfg_wr_en) orig_r <= cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r <= op_nxt; pos_r <= pos_nxt; cnt_r <= cnt_nxt; rem_r <= rem_nxt; ei_r <= ei_nxt;
    idx_r <= idx_nxt; j_r <= j_nxt; keep_r <= keep_nxt; base_r <= base_nxt;
    off_r <= off_nxt; e_r <= e_nxt; tail_r <= tail_nxt; wstep_r <= wstep_nxt;
    res_status_r <= res_status_nxt; res_valid_r <= res_valid_nxt;
    res_src_r <= res_src_nxt; res_st_r <= res_st_nxt; res_ln_r <= res_ln_nxt;
    cp_i_r <= cp_i_nxt; cp_stop_r <= cp_stop_nxt; cp_dist_r <= cp_dist_nxt;
    cp_up_r <= cp_up_nxt; cp_ret_r <= cp_ret_nxt;
    if (out_load) begin
      out_status_r <= res_status_r; out_pv_r <= res_valid_r; out_src_r <= res_src_r;
      out_st_r <= res_st_r; out_ln_r <= res_ln_r; out_doc_r <= total_r;
      out_cnt_r <= count_r;
    end
  end

  // Output beat.
  assign total_x            = {7'b0, out_cnt_r};
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_piece_valid    = out_pv_r;
  assign out_piece_from_add = out_src_r;
  assign out_piece_start    = out_st_r;
  assign out_piece_length   = out_ln_r;
  assign out_doc_length     = out_doc_r;
  assign out_piece_total    = total_x[6:0];

`ifndef NO_ASSERTIONS
  // The table never holds more descriptors than it has room for.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C) else $error("descriptor count beyond table size");

  // With no zero-length pieces, an empty document means an empty table.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((count_r == '0) == (total_r == '0)))
    else $error("document length and descriptor count disagree");

  // A copy step always moves a descriptor to another slot.
  a_cp_dist: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CPWR |-> cp_dist_r != '0) else $error("copy with zero distance");

  // A result is presented only after the sequencer finished an item.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE) else $error("result without item");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the piece descriptor table core.
`timescale 1ns / 100ps

module testbench;
  import pdt_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam longint unsigned POS_MASK = 64'hFF_FFFF;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [1:0]          op;
    logic [POS_BITS-1:0] position;
    logic [POS_BITS-1:0] count;
    logic [5:0]          entry_index;
  } edit_t;

  typedef struct {
    logic [1:0]          status;
    logic                piece_valid;
    logic                piece_from_add;
    logic [POS_BITS-1:0] piece_start;
    logic [POS_BITS-1:0] piece_length;
    logic [POS_BITS-1:0] doc_length;
    logic [6:0]          piece_total;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [POS_BITS-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_op = OP_QUERY;
  logic [POS_BITS-1:0] in_position = '0;
  logic [POS_BITS-1:0] in_count = '0;
  logic [5:0]          in_entry_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic                out_piece_valid;
  logic                out_piece_from_add;
  logic [POS_BITS-1:0] out_piece_start;
  logic [POS_BITS-1:0] out_piece_length;
  logic [POS_BITS-1:0] out_doc_length;
  logic [6:0]          out_piece_total;

  piece_descriptor_table_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_position(in_position), .in_count(in_count), .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_piece_valid(out_piece_valid), .out_piece_from_add(out_piece_from_add),
    .out_piece_start(out_piece_start), .out_piece_length(out_piece_length),
    .out_doc_length(out_doc_length), .out_piece_total(out_piece_total)
  );

  always #6 clk = ~clk;

  // Shadow copy of the descriptor table and its counters.
  ent_t            shadow_table[TABLE_SLOTS];
  int unsigned     shadow_count = 0;
  longint unsigned shadow_add_used = 0;
  longint unsigned shadow_doc_len = 0;
  longint unsigned shadow_orig_len = 0;

  edit_t    pending_edits[$];
  outcome_t expected_outcomes[$];
  int       edits_queued = 0;
  int       edits_taken = 0;
  int       error_count = 0;
  bit       took_beat = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_cycles = 0;
  bit       held_once = 1'b0;
  longint   cycle_count = 0;

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Index of the piece holding document position p, with the offset inside it.
  function automatic int find_piece(longint unsigned p, output longint unsigned off);
    longint unsigned base;
    base = 0;
    off = 0;
    for (int i = 0; i < shadow_count; i++) begin
      if (p >= base && p < base + shadow_table[i].length) begin
        off = p - base;
        return i;
      end
      base += shadow_table[i].length;
    end
    return int'(shadow_count);
  endfunction

  function automatic void open_gap(int at);
    for (int i = shadow_count; i > at; i--) shadow_table[i] = shadow_table[i-1];
    shadow_count++;
  endfunction

  function automatic void close_gap(int at);
    for (int i = at; i + 1 < shadow_count; i++) shadow_table[i] = shadow_table[i+1];
    shadow_count--;
  endfunction

  function automatic logic [1:0] apply_insert(longint unsigned p, longint unsigned c);
    longint unsigned off;
    int idx;
    int need;
    bit at_end;
    ent_t old;
    if (c == 0) return ST_NOP;
    if (shadow_add_used + c > POS_MASK || shadow_doc_len + c > POS_MASK) return ST_SPACE;
    off = 0;
    at_end = (shadow_count == 0 || p >= shadow_doc_len);
    idx = at_end ? shadow_count : find_piece(p, off);
    if (idx >= shadow_count) at_end = 1'b1;
    need = (at_end || off == 0) ? 1 : 2;
    if (shadow_count + need > TABLE_SLOTS) return ST_TABLE;
    if (at_end) begin
      open_gap(shadow_count);
      shadow_table[shadow_count-1] = '{1'b1, shadow_add_used[POS_BITS-1:0],
                                       c[POS_BITS-1:0]};
    end else if (off == 0) begin
      open_gap(idx);
      shadow_table[idx] = '{1'b1, shadow_add_used[POS_BITS-1:0], c[POS_BITS-1:0]};
    end else begin
      // Split the piece around the new run.
      old = shadow_table[idx];
      shadow_table[idx].length = POS_BITS'(off);
      open_gap(idx + 1);
      shadow_table[idx+1] = '{1'b1, shadow_add_used[POS_BITS-1:0], c[POS_BITS-1:0]};
      open_gap(idx + 2);
      shadow_table[idx+2] = '{old.from_add, POS_BITS'(old.start + off),
                              POS_BITS'(old.length - off)};
    end
    shadow_add_used = (shadow_add_used + c) & POS_MASK;
    shadow_doc_len = (shadow_doc_len + c) & POS_MASK;
    return ST_DONE;
  endfunction

  function automatic logic [1:0] apply_remove(longint unsigned p, longint unsigned c);
    longint unsigned left, off, len, take;
    int idx;
    ent_t old;
    if (c == 0 || p >= shadow_doc_len) return ST_NOP;
    left = c;
    if (left > shadow_doc_len - p) left = shadow_doc_len - p;
    idx = find_piece(p, off);
    if (idx >= shadow_count) return ST_NOP;
    if (off > 0 && off + left < shadow_table[idx].length && shadow_count >= TABLE_SLOTS)
      return ST_TABLE;
    shadow_doc_len -= left;
    while (left > 0) begin
      idx = find_piece(p, off);
      if (idx >= shadow_count) break;
      len = shadow_table[idx].length;
      take = len - off;
      if (take > left) take = left;
      if (off == 0 && take == len) begin
        close_gap(idx);
      end else if (off == 0) begin
        shadow_table[idx].start = POS_BITS'(shadow_table[idx].start + take);
        shadow_table[idx].length = POS_BITS'(len - take);
      end else if (off + take == len) begin
        shadow_table[idx].length = POS_BITS'(off);
      end else begin
        old = shadow_table[idx];
        shadow_table[idx].length = POS_BITS'(off);
        open_gap(idx + 1);
        shadow_table[idx+1] = '{old.from_add, POS_BITS'(old.start + off + take),
                                POS_BITS'(len - off - take)};
      end
      left -= take;
    end
    return ST_DONE;
  endfunction

  // Work out the result of one accepted edit and advance the shadow table.
  function automatic outcome_t predict_outcome(edit_t e);
    outcome_t r;
    r = '{default: '0};
    case (e.op)
      OP_INSERT: r.status = apply_insert(e.position, e.count);
      OP_REMOVE: r.status = apply_remove(e.position, e.count);
      OP_QUERY: begin
        if (e.entry_index < shadow_count) begin
          r.piece_valid = 1'b1;
          r.piece_from_add = shadow_table[e.entry_index].from_add;
          r.piece_start = shadow_table[e.entry_index].start;
          r.piece_length = shadow_table[e.entry_index].length;
        end else begin
          r.status = ST_NOP;
        end
      end
      default: begin
        shadow_add_used = 0;
        shadow_doc_len = shadow_orig_len;
        shadow_count = 0;
        if (shadow_orig_len != 0) begin
          shadow_count = 1;
          shadow_table[0] = '{1'b0, '0, shadow_orig_len[POS_BITS-1:0]};
        end
      end
    endcase
    r.doc_length = shadow_doc_len[POS_BITS-1:0];
    r.piece_total = 7'(shadow_count);
    return r;
  endfunction

  function automatic void report_field(string name, longint unsigned want, longint unsigned got);
    $display("%0t: mismatch in %s: expected %0h, actual %0h", $realtime, name, want, got);
    error_count++;
  endfunction

  // Input side accept and result checking, sampled at the rising edge.
  always @(posedge clk) begin
    outcome_t want;
    cycle_count++;
    took_beat = rst_n && in_valid && !in_stall;
    if (took_beat) begin
      expected_outcomes.push_back(predict_outcome('{in_op, in_position, in_count,
                                                    in_entry_index}));
      edits_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d", $realtime, out_status);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_status !== want.status) report_field("status", want.status, out_status);
        if (out_piece_valid !== want.piece_valid)
          report_field("piece_valid", want.piece_valid, out_piece_valid);
        if (out_piece_from_add !== want.piece_from_add)
          report_field("piece_from_add", want.piece_from_add, out_piece_from_add);
        if (out_piece_start !== want.piece_start)
          report_field("piece_start", want.piece_start, out_piece_start);
        if (out_piece_length !== want.piece_length)
          report_field("piece_length", want.piece_length, out_piece_length);
        if (out_doc_length !== want.doc_length)
          report_field("doc_length", want.doc_length, out_doc_length);
        if (out_piece_total !== want.piece_total)
          report_field("piece_total", want.piece_total, out_piece_total);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: holds a stalled beat, otherwise idles or offers the next edit.
  always @(negedge clk) begin
    edit_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took_beat) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_edits.size() > 0) begin
      e = pending_edits.pop_front();
      in_valid <= 1'b1;
      in_op <= e.op;
      in_position <= e.position;
      in_count <= e.count;
      in_entry_index <= e.entry_index;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, and one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (!held_once && edits_taken >= 300) begin
      held_once = 1'b1;
      hold_cycles = 1500;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      recv_gap = pick_gap();
    end
  end

  task automatic queue_edit(logic [1:0] op, longint unsigned p, longint unsigned c,
                            int unsigned idx);
    pending_edits.push_back('{op, p[POS_BITS-1:0], c[POS_BITS-1:0], idx[5:0]});
    edits_queued++;
  endtask

  task automatic wait_idle();
    while (edits_taken != edits_queued || expected_outcomes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_original_length(longint unsigned v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[POS_BITS-1:0];
    shadow_orig_len = v & POS_MASK;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random edit, positions mostly inside the current document.
  task automatic queue_random_edit();
    int r;
    longint unsigned p, c;
    r = $urandom_range(0, 99);
    p = (shadow_doc_len == 0 || $urandom_range(0, 19) == 0) ? $urandom :
        $urandom_range(0, int'(shadow_doc_len) + 2);
    c = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 9);
    if (r < 50) queue_edit(OP_INSERT, p, c, 0);
    else if (r < 75) queue_edit(OP_REMOVE, p, c, 0);
    else if (r < 98) queue_edit(OP_QUERY, 0, 0, $urandom_range(0, 63));
    else queue_edit(OP_RESTART, 0, 0, 0);
  endtask

  task automatic run_random_phase(longint unsigned orig, int edits);
    write_original_length(orig);
    queue_edit(OP_RESTART, 0, 0, 0);
    for (int i = 0; i < edits; i++) begin
      while (pending_edits.size() > 3) @(negedge clk);
      queue_random_edit();
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, restart, splits, trims, zero counts and the full cases.
    write_original_length(40);
    queue_edit(OP_QUERY, 0, 0, 0);
    queue_edit(OP_REMOVE, 0, 5, 0);
    queue_edit(OP_INSERT, 0, 3, 0);
    queue_edit(OP_RESTART, 0, 0, 0);
    queue_edit(OP_INSERT, 0, 0, 0);
    queue_edit(OP_REMOVE, 5, 0, 0);
    queue_edit(OP_INSERT, 0, 4, 0);
    queue_edit(OP_INSERT, 10, 6, 0);
    queue_edit(OP_INSERT, POS_MASK, 2, 0);
    queue_edit(OP_INSERT, 20, 1, 0);
    queue_edit(OP_QUERY, 0, 0, 2);
    queue_edit(OP_QUERY, 0, 0, 63);
    queue_edit(OP_REMOVE, 30, 2, 0);
    queue_edit(OP_REMOVE, 2, 12, 0);
    queue_edit(OP_REMOVE, POS_MASK, POS_MASK, 0);
    queue_edit(OP_REMOVE, 40, POS_MASK, 0);
    queue_edit(OP_INSERT, 1, POS_MASK, 0);
    queue_edit(OP_INSERT, 1, 24'h7F_FFF0, 0);
    queue_edit(OP_INSERT, 0, 24'h7F_FFF0, 0);
    queue_edit(OP_QUERY, 0, 0, 1);
    queue_edit(OP_REMOVE, 0, POS_MASK, 0);
    queue_edit(OP_QUERY, 0, 0, 0);
    // Fill the table with one-character appends past its size, then try an insert at the front.
    for (int i = 0; i < 66; i++) queue_edit(OP_INSERT, POS_MASK, 1, 0);
    queue_edit(OP_INSERT, 0, 1, 0);
    queue_edit(OP_QUERY, 0, 0, 63);
    queue_edit(OP_REMOVE, 0, POS_MASK, 0);

    run_random_phase(0, 300);
    run_random_phase(1, 230);
    run_random_phase(POS_MASK, 50);
    run_random_phase($urandom_range(1, 1000), 230);
    run_random_phase($urandom, 20);
    run_random_phase(200, 180);

    wait_idle();
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pdt_pkg.sv
design/piece_descriptor_table_core.sv
tb/sv/testbench.sv
